// File: design/edrp_pkg.sv
// Shared types and constants for the e-paper dirty-rectangle refresh policy block.
// Holds the transfer structs, the action, refresh mode and register index codes.
// No dependencies.
package edrp_pkg;

  // Panel limits of this build. Configured geometry is clamped to these.
  localparam int MAX_WIDTH_BYTES = 128;
  localparam int MAX_HEIGHT      = 1024;
  localparam int WIDTH_CAP  = (MAX_WIDTH_BYTES < 128) ? MAX_WIDTH_BYTES : 128;
  localparam int HEIGHT_CAP = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

  // Configuration data is as wide as the widest register (frame_height).
  localparam int CFG_DATA_W = 11;

  // Register reset values.
  localparam logic [7:0]  RST_WIDTH_BYTES   = 8'd35;
  localparam logic [10:0] RST_FRAME_HEIGHT  = 11'd480;
  localparam logic [4:0]  RST_PARTIAL_LIMIT = 5'd20;

  typedef enum logic [1:0] {
    ACT_BYTE_PAIR = 2'd0,
    ACT_ARM_SHOT  = 2'd1,
    ACT_WAKEUP    = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    MODE_NONE      = 2'd0,
    MODE_INIT_FULL = 2'd1,
    MODE_FULL      = 2'd2,
    MODE_PARTIAL   = 2'd3
  } refresh_mode_t;

  typedef enum logic [1:0] {
    CFG_WIDTH_BYTES   = 2'd0,
    CFG_FRAME_HEIGHT  = 2'd1,
    CFG_KEEP_PARTIAL  = 2'd2,
    CFG_PARTIAL_LIMIT = 2'd3
  } cfg_index_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] current_byte;
    logic [7:0] previous_byte;
    logic       last_of_frame;
  } in_item_t;

  typedef struct packed {
    refresh_mode_t refresh_mode;
    logic [9:0]    rect_x;
    logic [9:0]    rect_y;
    logic [10:0]   rect_w;
    logic [10:0]   rect_h;
  } out_item_t;

endpackage

// File: design/epaper_dirty_rect_refresh_policy.sv
// Pipeline: an accepted transfer lands in the input register and is evaluated from there;
// its decision is then loaded into the output register, unless a held decision stalls it.
// Throughput: one input transfer per cycle; only a decision held by out_stall can back up.
// Reset (rst_n low, synchronous): both pipeline registers empty, box cleared, an initial
// full refresh pending, registers back to 35 bytes, 480 rows, force off, limit 20.
//
// Top level of the e-paper dirty-rectangle refresh policy. Depends on edrp_pkg.
module epaper_dirty_rect_refresh_policy (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input channel: frame byte pairs and control actions.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  edrp_pkg::in_item_t            in_data,
  // Result channel: one refresh decision per frame.
  output logic                          out_valid,
  input  logic                          out_stall,
  output edrp_pkg::out_item_t           out_data,
  // Configuration write port.
  input  logic                          cfg_wr_en,
  input  logic [1:0]                    cfg_addr,
  input  logic [edrp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [7:0]  W_CAP = 8'(edrp_pkg::WIDTH_CAP);
  localparam logic [10:0] H_CAP = 11'(edrp_pkg::HEIGHT_CAP);

  // Configuration registers.
  logic [7:0]  width_bytes_r;
  logic [10:0] frame_height_r;
  logic        keep_partial_r;
  logic [4:0]  partial_limit_r;

  // Input register. It decouples in_stall from the decision logic and lets a new
  // transfer come in while the previous one is being evaluated.
  logic                 in_valid_r, in_valid_nxt;
  edrp_pkg::in_item_t   in_data_r;

  // Output register. It holds a finished decision until the consumer takes it.
  logic                 out_valid_r, out_valid_nxt;
  edrp_pkg::out_item_t  out_data_r, out_data_nxt;

  // Raster position and dirty bounding box.
  logic [6:0] column_pos_r, column_pos_nxt;
  logic [9:0] row_pos_r, row_pos_nxt;
  logic [9:0] min_row_r, min_row_nxt;
  logic [9:0] max_row_r, max_row_nxt;
  logic [6:0] min_col_r, min_col_nxt;
  logic [6:0] max_col_r, max_col_nxt;
  logic       any_change_r, any_change_nxt;

  // Policy state.
  logic       initial_pending_r, initial_pending_nxt;
  logic       one_shot_armed_r, one_shot_armed_nxt;
  logic [4:0] partial_run_count_r, partial_run_count_nxt;

  // Decision datapath.
  logic [7:0]  w_eff;
  logic [10:0] h_eff;
  logic [4:0]  limit_eff;
  logic [10:0] px_w;
  logic        gives_result;
  logic        proceed;
  logic        in_box;
  logic [9:0]  box_min_row, box_max_row;
  logic [6:0]  box_min_col, box_max_col;
  logic        box_any;
  logic [7:0]  box_w_bytes;
  logic [10:0] box_h;
  logic [18:0] box_area;
  logic [18:0] panel_area;
  logic        area_big;
  logic        full;
  logic [6:0]  col_inc;

  // Effective geometry: zero reads as one, larger values clamp to the build limits.
  always_comb begin
    if (width_bytes_r == 8'd0) begin
      w_eff = 8'd1;
    end else if (width_bytes_r > W_CAP) begin
      w_eff = W_CAP;
    end else begin
      w_eff = width_bytes_r;
    end
    if (frame_height_r == 11'd0) begin
      h_eff = 11'd1;
    end else if (frame_height_r > H_CAP) begin
      h_eff = H_CAP;
    end else begin
      h_eff = frame_height_r;
    end
    limit_eff = (partial_limit_r == 5'd0) ? 5'd1 : partial_limit_r;
    px_w      = {w_eff, 3'b000};
  end

  // Only the last byte pair of a frame yields a decision. Any other transfer may
  // move on even while the output register is held by the consumer.
  assign gives_result = in_valid_r && (in_data_r.action == edrp_pkg::ACT_BYTE_PAIR)
                        && in_data_r.last_of_frame;
  assign proceed  = in_valid_r && (!gives_result || !out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !proceed;

  // Fold the current byte into the box. A byte that lies outside the configured
  // panel still advances the raster position but never widens the box.
  assign in_box = (in_data_r.current_byte != in_data_r.previous_byte)
                  && ({1'b0, column_pos_r} < w_eff) && ({1'b0, row_pos_r} < h_eff);

  always_comb begin
    box_min_row = (in_box && (row_pos_r < min_row_r)) ? row_pos_r : min_row_r;
    box_max_row = (in_box && (row_pos_r > max_row_r)) ? row_pos_r : max_row_r;
    box_min_col = (in_box && (column_pos_r < min_col_r)) ? column_pos_r : min_col_r;
    box_max_col = (in_box && (column_pos_r > max_col_r)) ? column_pos_r : max_col_r;
    box_any     = any_change_r || in_box;
  end

  // Area test in byte columns: twice the box area against the panel area. Both
  // sides carry the same factor of eight pixels per byte, so it cancels. The
  // values are only meaningful when the box holds at least one change.
  assign box_w_bytes = 8'({1'b0, box_max_col} - {1'b0, box_min_col} + 8'd1);
  assign box_h       = 11'({1'b0, box_max_row} - {1'b0, box_min_row} + 11'd1);
  assign box_area    = {11'd0, box_w_bytes} * {8'd0, box_h};
  assign panel_area  = {11'd0, w_eff} * {8'd0, h_eff};
  assign area_big    = {box_area, 1'b0} > {1'b0, panel_area};

  assign col_inc = column_pos_r + 7'd1;

  always_comb begin
    column_pos_nxt        = column_pos_r;
    row_pos_nxt           = row_pos_r;
    min_row_nxt           = min_row_r;
    max_row_nxt           = max_row_r;
    min_col_nxt           = min_col_r;
    max_col_nxt           = max_col_r;
    any_change_nxt        = any_change_r;
    initial_pending_nxt   = initial_pending_r;
    one_shot_armed_nxt    = one_shot_armed_r;
    partial_run_count_nxt = partial_run_count_r;
    out_data_nxt          = out_data_r;
    full                  = 1'b0;
    in_valid_nxt          = in_valid_r;
    out_valid_nxt         = out_valid_r && out_stall;

    if (proceed) begin
      case (in_data_r.action)
        edrp_pkg::ACT_ARM_SHOT: begin
          one_shot_armed_nxt = 1'b1;
        end
        edrp_pkg::ACT_WAKEUP: begin
          initial_pending_nxt = 1'b1;
        end
        edrp_pkg::ACT_BYTE_PAIR: begin
          if (!in_data_r.last_of_frame) begin
            min_row_nxt    = box_min_row;
            max_row_nxt    = box_max_row;
            min_col_nxt    = box_min_col;
            max_col_nxt    = box_max_col;
            any_change_nxt = box_any;
            // Column wraps at the panel width or at its own range; the row then advances.
            if (({1'b0, col_inc} >= w_eff) || (col_inc == 7'd0)) begin
              column_pos_nxt = 7'd0;
              row_pos_nxt    = row_pos_r + 10'd1;
            end else begin
              column_pos_nxt = col_inc;
            end
          end else begin
            out_valid_nxt = 1'b1;
            if (initial_pending_r) begin
              // First frame after wakeup always gets a full refresh.
              initial_pending_nxt       = 1'b0;
              out_data_nxt.refresh_mode = edrp_pkg::MODE_INIT_FULL;
              out_data_nxt.rect_x       = 10'd0;
              out_data_nxt.rect_y       = 10'd0;
              out_data_nxt.rect_w       = px_w;
              out_data_nxt.rect_h       = h_eff;
            end else if (!box_any) begin
              out_data_nxt.refresh_mode = edrp_pkg::MODE_NONE;
              out_data_nxt.rect_x       = 10'd0;
              out_data_nxt.rect_y       = 10'd0;
              out_data_nxt.rect_w       = 11'd0;
              out_data_nxt.rect_h       = 11'd0;
            end else begin
              full = (area_big && !keep_partial_r)
                     || (keep_partial_r && (partial_run_count_r >= limit_eff));
              if (keep_partial_r && one_shot_armed_r) begin
                one_shot_armed_nxt = 1'b0;
              end
              if (full) begin
                partial_run_count_nxt     = 5'd0;
                out_data_nxt.refresh_mode = edrp_pkg::MODE_FULL;
                out_data_nxt.rect_x       = 10'd0;
                out_data_nxt.rect_y       = 10'd0;
                out_data_nxt.rect_w       = px_w;
                out_data_nxt.rect_h       = h_eff;
              end else begin
                if (partial_run_count_r < limit_eff) begin
                  partial_run_count_nxt = partial_run_count_r + 5'd1;
                end
                out_data_nxt.refresh_mode = edrp_pkg::MODE_PARTIAL;
                if (keep_partial_r && one_shot_armed_r) begin
                  // An armed one-shot widens the partial update to the whole panel.
                  out_data_nxt.rect_x = 10'd0;
                  out_data_nxt.rect_y = 10'd0;
                  out_data_nxt.rect_w = px_w;
                  out_data_nxt.rect_h = h_eff;
                end else begin
                  out_data_nxt.rect_x = {box_min_col, 3'b000};
                  out_data_nxt.rect_y = box_min_row;
                  out_data_nxt.rect_w = {box_w_bytes, 3'b000};
                  out_data_nxt.rect_h = box_h;
                end
              end
            end
            // Every decision starts a fresh frame.
            column_pos_nxt = 7'd0;
            row_pos_nxt    = 10'd0;
            min_row_nxt    = '1;
            max_row_nxt    = 10'd0;
            min_col_nxt    = '1;
            max_col_nxt    = 7'd0;
            any_change_nxt = 1'b0;
          end
        end
        default: begin
          // The unused action code is dropped without effect.
        end
      endcase
    end

    // Writing keep_partial restarts the forced partial run.
    if (cfg_wr_en && (edrp_pkg::cfg_index_t'(cfg_addr) == edrp_pkg::CFG_KEEP_PARTIAL)) begin
      partial_run_count_nxt = 5'd0;
    end

    if (in_valid && !in_stall) begin
      in_valid_nxt = 1'b1;
    end else if (proceed) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_bytes_r       <= edrp_pkg::RST_WIDTH_BYTES;
      frame_height_r      <= edrp_pkg::RST_FRAME_HEIGHT;
      keep_partial_r      <= 1'b0;
      partial_limit_r     <= edrp_pkg::RST_PARTIAL_LIMIT;
      in_valid_r          <= 1'b0;
      out_valid_r         <= 1'b0;
      column_pos_r        <= 7'd0;
      row_pos_r           <= 10'd0;
      min_row_r           <= '1;
      max_row_r           <= 10'd0;
      min_col_r           <= '1;
      max_col_r           <= 7'd0;
      any_change_r        <= 1'b0;
      initial_pending_r   <= 1'b1;
      one_shot_armed_r    <= 1'b0;
      partial_run_count_r <= 5'd0;
    end else begin
      if (cfg_wr_en) begin
        case (edrp_pkg::cfg_index_t'(cfg_addr))
          edrp_pkg::CFG_WIDTH_BYTES:   width_bytes_r   <= cfg_wdata[7:0];
          edrp_pkg::CFG_FRAME_HEIGHT:  frame_height_r  <= cfg_wdata[10:0];
          edrp_pkg::CFG_KEEP_PARTIAL:  keep_partial_r  <= cfg_wdata[0];
          edrp_pkg::CFG_PARTIAL_LIMIT: partial_limit_r <= cfg_wdata[4:0];
          default: begin
          end
        endcase
      end
      in_valid_r          <= in_valid_nxt;
      out_valid_r         <= out_valid_nxt;
      column_pos_r        <= column_pos_nxt;
      row_pos_r           <= row_pos_nxt;
      min_row_r           <= min_row_nxt;
      max_row_r           <= max_row_nxt;
      min_col_r           <= min_col_nxt;
      max_col_r           <= max_col_nxt;
      any_change_r        <= any_change_nxt;
      initial_pending_r   <= initial_pending_nxt;
      one_shot_armed_r    <= one_shot_armed_nxt;
      partial_run_count_r <= partial_run_count_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/edrp_checker.sv
// Port-level checks for the e-paper dirty-rectangle refresh policy block.
// Depends on edrp_pkg; bound to epaper_dirty_rect_refresh_policy at the end of this file.
module edrp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input edrp_pkg::out_item_t out_data
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A held result stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // The input side only backs up when the consumer holds a result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // A no-update decision carries an empty rectangle.
  a_none_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.refresh_mode == edrp_pkg::MODE_NONE) |->
      (out_data.rect_x == 10'd0) && (out_data.rect_y == 10'd0)
      && (out_data.rect_w == 11'd0) && (out_data.rect_h == 11'd0))
    else $error("no-update decision with a nonempty rectangle");

  // Any refresh covers at least one byte column and one row, on byte boundaries.
  a_rect_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.refresh_mode != edrp_pkg::MODE_NONE) |->
      (out_data.rect_w != 11'd0) && (out_data.rect_w[2:0] == 3'd0)
      && (out_data.rect_h != 11'd0) && (out_data.rect_x[2:0] == 3'd0))
    else $error("refresh rectangle is empty or not byte aligned");

endmodule

bind epaper_dirty_rect_refresh_policy edrp_checker u_edrp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: bench/edrp_decision_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the e-paper dirty-rectangle refresh policy: watches the input, result and
// register write ports, tracks the frame bounding box on its own and compares every decision.
// Depends on edrp_pkg for the transfer structs, codes and register reset values.
module edrp_decision_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  edrp_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  edrp_pkg::out_item_t             out_data,
  input  logic                            cfg_wr_en,
  input  logic [1:0]                      cfg_addr,
  input  logic [edrp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              mismatch_count,
  output int                              decisions_outstanding
);

  // Register shadows.
  logic [7:0]  cfg_width;
  logic [10:0] cfg_height;
  logic        cfg_keep;
  logic [4:0]  cfg_limit;

  // Frame tracking state.
  logic [6:0] col_pos;
  logic [9:0] row_pos;
  logic [9:0] min_row;
  logic [9:0] max_row;
  logic [6:0] min_col;
  logic [6:0] max_col;
  logic       changed;
  logic       init_pending;
  logic       shot_armed;
  logic [4:0] run_count;

  edrp_pkg::out_item_t decisions_due[$];

  function automatic void clear_frame_box();
    col_pos = '0;
    row_pos = '0;
    min_row = '1;
    max_row = '0;
    min_col = '1;
    max_col = '0;
    changed = 1'b0;
  endfunction

  // Advances the tracker by one input transfer; returns 1 when a decision is due.
  function automatic bit predict_refresh_decision(input edrp_pkg::in_item_t item,
                                                  output edrp_pkg::out_item_t decision);
    int  w, h, lim, px_w, rx, ry, rw, rh;
    bit  full_refresh;
    w = (cfg_width == 0) ? 1
        : ((cfg_width > edrp_pkg::WIDTH_CAP) ? edrp_pkg::WIDTH_CAP : cfg_width);
    h = (cfg_height == 0) ? 1
        : ((cfg_height > edrp_pkg::HEIGHT_CAP) ? edrp_pkg::HEIGHT_CAP : cfg_height);
    lim = (cfg_limit == 0) ? 1 : cfg_limit;
    px_w = w * 8;
    decision = '0;
    if (item.action == edrp_pkg::ACT_ARM_SHOT) begin
      shot_armed = 1'b1;
      return 1'b0;
    end
    if (item.action == edrp_pkg::ACT_WAKEUP) begin
      init_pending = 1'b1;
      return 1'b0;
    end
    if (item.action != edrp_pkg::ACT_BYTE_PAIR) return 1'b0;

    // Bytes outside the configured panel move the position but never grow the box.
    if (item.current_byte != item.previous_byte && col_pos < w && row_pos < h) begin
      if (row_pos < min_row) min_row = row_pos;
      if (row_pos > max_row) max_row = row_pos;
      if (col_pos < min_col) min_col = col_pos;
      if (col_pos > max_col) max_col = col_pos;
      changed = 1'b1;
    end

    if (!item.last_of_frame) begin
      col_pos = col_pos + 7'd1;
      if (col_pos >= w || col_pos == 0) begin
        col_pos = '0;
        row_pos = row_pos + 10'd1;
      end
      return 1'b0;
    end

    if (init_pending) begin
      init_pending = 1'b0;
      decision.refresh_mode = edrp_pkg::MODE_INIT_FULL;
      decision.rect_w = 11'(px_w);
      decision.rect_h = 11'(h);
    end else if (!changed) begin
      decision.refresh_mode = edrp_pkg::MODE_NONE;
    end else begin
      rx = int'(min_col) * 8;
      ry = int'(min_row);
      rw = (int'(max_col) - int'(min_col) + 1) * 8;
      rh = int'(max_row) - int'(min_row) + 1;
      if (cfg_keep && shot_armed) begin
        rx = 0;
        ry = 0;
        rw = px_w;
        rh = h;
        shot_armed = 1'b0;
      end
      full_refresh = (rw * rh * 2 > px_w * h) && !cfg_keep;
      if (cfg_keep && run_count >= lim) full_refresh = 1'b1;
      if (full_refresh) begin
        run_count = '0;
        decision.refresh_mode = edrp_pkg::MODE_FULL;
        decision.rect_w = 11'(px_w);
        decision.rect_h = 11'(h);
      end else begin
        if (run_count < lim) run_count = run_count + 5'd1;
        decision.refresh_mode = edrp_pkg::MODE_PARTIAL;
        decision.rect_x = 10'(rx);
        decision.rect_y = 10'(ry);
        decision.rect_w = 11'(rw);
        decision.rect_h = 11'(rh);
      end
    end
    clear_frame_box();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] decision check: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin
    edrp_pkg::out_item_t predicted;
    edrp_pkg::out_item_t oldest;
    if (!rst_n) begin
      cfg_width = edrp_pkg::RST_WIDTH_BYTES;
      cfg_height = edrp_pkg::RST_FRAME_HEIGHT;
      cfg_keep = 1'b0;
      cfg_limit = edrp_pkg::RST_PARTIAL_LIMIT;
      clear_frame_box();
      init_pending = 1'b1;
      shot_armed = 1'b0;
      run_count = '0;
      decisions_due.delete();
    end else begin
      if (cfg_wr_en) begin
        case (edrp_pkg::cfg_index_t'(cfg_addr))
          edrp_pkg::CFG_WIDTH_BYTES:  cfg_width = cfg_wdata[7:0];
          edrp_pkg::CFG_FRAME_HEIGHT: cfg_height = cfg_wdata[10:0];
          edrp_pkg::CFG_KEEP_PARTIAL: begin
            cfg_keep = cfg_wdata[0];
            run_count = '0;
          end
          edrp_pkg::CFG_PARTIAL_LIMIT: cfg_limit = cfg_wdata[4:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (predict_refresh_decision(in_data, predicted)) decisions_due.push_back(predicted);
      end
      if (out_valid && !out_stall) begin
        if (decisions_due.size() == 0) begin
          report_mismatch($sformatf("decision with mode %0d arrived with none due",
                                    out_data.refresh_mode));
        end else begin
          oldest = decisions_due.pop_front();
          check_field("refresh_mode", out_data.refresh_mode, oldest.refresh_mode);
          check_field("rect_x", out_data.rect_x, oldest.rect_x);
          check_field("rect_y", out_data.rect_y, oldest.rect_y);
          check_field("rect_w", out_data.rect_w, oldest.rect_w);
          check_field("rect_h", out_data.rect_h, oldest.rect_h);
        end
      end
    end
    decisions_outstanding <= decisions_due.size();
  end

endmodule

// File: bench/tb_epaper_dirty_rect_refresh_policy.sv
`timescale 1ns / 100ps
// Top of the bench for the e-paper dirty-rectangle refresh policy: makes frame and control
// stimulus, register writes and receiver back-pressure, and gives the verdict.
// Depends on edrp_pkg, the block under test and edrp_decision_checker.
module tb_epaper_dirty_rect_refresh_policy;

  // Generous bound on the whole run; the slowest legal run stays far below it.
  localparam int CYCLE_LIMIT   = 400_000;
  // A transfer passes the input register before it reaches the output register; leave some slack.
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_ITEMS  = 400;
  localparam int PRESSURE_HOLD = 80;
  localparam int CFG_W         = edrp_pkg::CFG_DATA_W;
  // The action field has one encoding the block must ignore.
  localparam edrp_pkg::action_t ACT_UNDEFINED = edrp_pkg::action_t'(2'd3);

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  edrp_pkg::in_item_t   in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  edrp_pkg::out_item_t  out_data;
  logic                 cfg_wr_en = 1'b0;
  edrp_pkg::cfg_index_t cfg_addr = edrp_pkg::CFG_WIDTH_BYTES;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // Stimulus controls shared with the receiver process; written only with nonblocking
  // assignments so the receiver never sees them in a race.
  logic idle_on = 1'b1;
  logic pressure_go = 1'b0;

  int mismatch_count;
  int decisions_outstanding;

  // Raw register values as last written, used only to size frames.
  logic [7:0]  shadow_width = edrp_pkg::RST_WIDTH_BYTES;
  logic [10:0] shadow_height = edrp_pkg::RST_FRAME_HEIGHT;
  int          panel_bytes;
  int          random_items;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  epaper_dirty_rect_refresh_policy i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  edrp_decision_checker i_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_data               (in_data),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_data              (out_data),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_addr              (cfg_addr),
    .cfg_wdata             (cfg_wdata),
    .mismatch_count        (mismatch_count),
    .decisions_outstanding (decisions_outstanding)
  );

  // Receiver. Normally it stalls now and then in random bursts, only while idling is on. The first
  // time the pressure request is seen it holds off for a long stretch, so that the block's
  // output and pipeline registers fill and the block has to stall its input side.
  int   stall_left = 0;
  logic pressure_seen = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (pressure_go && !pressure_seen) begin
      pressure_seen = 1'b1;
      stall_left = PRESSURE_HOLD - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offers one transfer and returns at the edge where it is accepted. A valid that stays
  // high for the next transfer is never lowered in between, and the payload holds while
  // the block stalls.
  task automatic send_item(input edrp_pkg::action_t act, input logic [7:0] cur,
                           input logic [7:0] prev, input logic last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{act, cur, prev, last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Streams n byte pairs of one frame. The first quiet pairs are equal; after that each pair
  // differs with the given percentage. Control transfers are sprinkled in now and then, and
  // when close is clear the frame is left open with no last byte.
  task automatic send_frame(input int n, input int quiet, input int pct, input bit close);
    logic [7:0]        old_byte;
    logic [7:0]        flip;
    edrp_pkg::action_t ctl;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 6) begin
        case ($urandom_range(0, 2))
          0:       ctl = edrp_pkg::ACT_ARM_SHOT;
          1:       ctl = edrp_pkg::ACT_WAKEUP;
          default: ctl = ACT_UNDEFINED;
        endcase
        send_item(ctl, 8'($urandom), 8'($urandom), 1'($urandom));
      end
      old_byte = 8'($urandom);
      flip = (i >= quiet && $urandom_range(0, 99) < pct) ? 8'($urandom_range(1, 255)) : 8'd0;
      send_item(edrp_pkg::ACT_BYTE_PAIR, old_byte ^ flip, old_byte, close && i == n - 1);
      random_items++;
    end
  endtask

  // Brings the block to rest: every due decision has been taken, and a trailing transfer
  // that causes no decision has had time to leave the pipeline.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (decisions_outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the registers selected by mask, one per cycle, in index order.
  task automatic write_regs(input logic [3:0] mask, input logic [7:0] w,
                            input logic [10:0] h, input logic fp, input logic [4:0] lim);
    logic [CFG_W-1:0] vals[4];
    int               ew, eh;
    vals[edrp_pkg::CFG_WIDTH_BYTES]   = CFG_W'(w);
    vals[edrp_pkg::CFG_FRAME_HEIGHT]  = CFG_W'(h);
    vals[edrp_pkg::CFG_KEEP_PARTIAL]  = CFG_W'(fp);
    vals[edrp_pkg::CFG_PARTIAL_LIMIT] = CFG_W'(lim);
    for (int r = 0; r < 4; r++) begin
      if (mask[r]) begin
        cfg_wr_en <= 1'b1;
        cfg_addr <= edrp_pkg::cfg_index_t'(r);
        cfg_wdata <= vals[r];
        @(posedge clk);
      end
    end
    cfg_wr_en <= 1'b0;
    if (mask[edrp_pkg::CFG_WIDTH_BYTES]) shadow_width = w;
    if (mask[edrp_pkg::CFG_FRAME_HEIGHT]) shadow_height = h;
    ew = (shadow_width == 0) ? 1
         : ((shadow_width > edrp_pkg::WIDTH_CAP) ? edrp_pkg::WIDTH_CAP : shadow_width);
    eh = (shadow_height == 0) ? 1
         : ((shadow_height > edrp_pkg::HEIGHT_CAP) ? edrp_pkg::HEIGHT_CAP : shadow_height);
    panel_bytes = ew * eh;
  endtask

  // Watchdog: a hung handshake or a decision that never comes ends the run here.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int          n_frames, len, pct, quiet;
    logic [7:0]  w;
    logic [10:0] h;
    logic [4:0]  lim;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part on a 2 x 2 byte panel, limit 3, area rule active.
    write_regs(4'b1111, 8'd2, 11'd2, 1'b0, 5'd3);
    // The first frame after reset is an initial full refresh, even with nothing changed.
    send_item(edrp_pkg::ACT_BYTE_PAIR, 8'h00, 8'h00, 1'b1);
    // A frame with no difference gives no update.
    send_item(edrp_pkg::ACT_BYTE_PAIR, 8'hFF, 8'hFF, 1'b0);
    send_item(edrp_pkg::ACT_BYTE_PAIR, 8'h00, 8'h00, 1'b0);
    send_item(edrp_pkg::ACT_BYTE_PAIR, 8'hFF, 8'hFF, 1'b0);
    send_item(edrp_pkg::ACT_BYTE_PAIR, 8'h5A, 8'h5A, 1'b1);
    // One differing byte at row 0, column 1: a small partial box.
    send_item(edrp_pkg::ACT_BYTE_PAIR, 8'h00, 8'h00, 1'b0);
    send_item(edrp_pkg::ACT_BYTE_PAIR, 8'hFF, 8'h00, 1'b0);
    send_item(edrp_pkg::ACT_BYTE_PAIR, 8'h00, 8'h00, 1'b0);
    send_item(edrp_pkg::ACT_BYTE_PAIR, 8'hAA, 8'hAA, 1'b1);
    // Opposite corners: the box covers the panel, so the area rule forces a full refresh.
    send_item(edrp_pkg::ACT_BYTE_PAIR, 8'h01, 8'h00, 1'b0);
    send_item(edrp_pkg::ACT_BYTE_PAIR, 8'h55, 8'h55, 1'b0);
    send_item(edrp_pkg::ACT_BYTE_PAIR, 8'h00, 8'h00, 1'b0);
    send_item(edrp_pkg::ACT_BYTE_PAIR, 8'h80, 8'h00, 1'b1);
    // Wakeup marks an initial refresh; the unknown action is dropped whatever it carries.
    send_item(edrp_pkg::ACT_WAKEUP, 8'hFF, 8'h00, 1'b1);
    send_item(ACT_UNDEFINED, 8'hFF, 8'h00, 1'b1);
    send_item(edrp_pkg::ACT_BYTE_PAIR, 8'h7F, 8'hFE, 1'b1);
    // The one-shot is armed without keep_partial, so it stays armed and is not used yet.
    send_item(edrp_pkg::ACT_ARM_SHOT, 8'h00, 8'hFF, 1'b1);
    send_item(edrp_pkg::ACT_BYTE_PAIR, 8'h00, 8'h01, 1'b1);
    settle();
    write_regs(4'b0100, 8'd2, 11'd2, 1'b1, 5'd3);
    // With keep_partial set, the armed one-shot widens the box to the whole panel.
    send_item(edrp_pkg::ACT_BYTE_PAIR, 8'h10, 8'h00, 1'b1);
    // Too many bytes: the only differences fall on row 2, outside the panel, so no update.
    send_item(edrp_pkg::ACT_BYTE_PAIR, 8'h00, 8'h00, 1'b0);
    send_item(edrp_pkg::ACT_BYTE_PAIR, 8'h00, 8'h00, 1'b0);
    send_item(edrp_pkg::ACT_BYTE_PAIR, 8'h00, 8'h00, 1'b0);
    send_item(edrp_pkg::ACT_BYTE_PAIR, 8'h00, 8'h00, 1'b0);
    send_item(edrp_pkg::ACT_BYTE_PAIR, 8'hFF, 8'h00, 1'b0);
    send_item(edrp_pkg::ACT_BYTE_PAIR, 8'h00, 8'hFF, 1'b1);
    settle();

    // Back-pressure: one-byte frames so every transfer makes a decision, while the
    // receiver holds off long enough for the block to stall its input.
    write_regs(4'b0011, 8'd1, 11'd1, 1'b0, 5'd3);
    pressure_go <= 1'b1;
    repeat (24) begin
      send_item(edrp_pkg::ACT_BYTE_PAIR, 8'($urandom), 8'($urandom), 1'b1);
    end
    settle();

    // Widest panel: a change only in the last column, then a whole row changed.
    write_regs(4'b1111, 8'd128, 11'd2, 1'b1, 5'd31);
    send_frame(128, 127, 100, 1'b1);
    settle();
    write_regs(4'b0100, 8'd128, 11'd2, 1'b0, 5'd31);
    send_frame(128, 0, 100, 1'b1);
    settle();

    // Tallest panel, one byte wide: changes only well down the panel.
    write_regs(4'b1111, 8'd1, 11'd1024, 1'b1, 5'd31);
    send_frame(200, $urandom_range(100, 190), 20, 1'b1);

    // Random part: short phases, each with a fresh register setting. Geometry is mostly
    // tiny so that decisions come often; large and out-of-range values appear now and then
    // with truncated frames. The last fifth of it runs without idling on either side.
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      settle();
      idle_on <= (random_items < RANDOM_ITEMS * 4 / 5);
      case ($urandom_range(0, 9))
        0:       w = 8'd0;
        1:       w = 8'd128;
        2:       w = 8'd255;
        3:       w = 8'($urandom_range(5, 127));
        default: w = 8'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 9))
        0:       h = 11'd0;
        1:       h = 11'd1024;
        2:       h = 11'd2047;
        3:       h = 11'($urandom_range(5, 1023));
        default: h = 11'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 5))
        0:       lim = 5'd0;
        1:       lim = 5'd31;
        default: lim = 5'($urandom_range(1, 4));
      endcase
      write_regs(4'($urandom_range(1, 15)), w, h, 1'($urandom), lim);
      n_frames = $urandom_range(3, 10);
      for (int f = 0; f < n_frames && random_items < RANDOM_ITEMS; f++) begin
        if (panel_bytes <= 64) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: len = panel_bytes;
            6, 7:             len = $urandom_range(1, panel_bytes);
            default:          len = panel_bytes + $urandom_range(1, 4);
          endcase
        end else begin
          len = $urandom_range(1, 64);
        end
        case ($urandom_range(0, 7))
          0:       pct = 0;
          1:       pct = 100;
          default: pct = $urandom_range(5, 60);
        endcase
        quiet = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len) : 0;
        // The last frame of a phase is sometimes left open across the register change.
        send_frame(len, quiet, pct, (f < n_frames - 1) || ($urandom_range(0, 3) != 0));
      end
    end
    settle();

    if (mismatch_count == 0 && decisions_outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
design/edrp_pkg.sv
design/epaper_dirty_rect_refresh_policy.sv
design/edrp_checker.sv
bench/edrp_decision_checker.sv
bench/tb_epaper_dirty_rect_refresh_policy.sv
